>>> hw/rtl/arpc_pkg.sv
// Shared types, constants and codes of the ARP cache table.
package arpc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int SLOT_W  = 4;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   localparam logic [31:0] BCAST_IP  = 32'hffff_ffff;
   localparam logic [47:0] BCAST_MAC = 48'hffff_ffff_ffff;

   localparam logic FUNC_QUERY = 1'b0;
   localparam logic FUNC_PUT   = 1'b1;

   localparam logic [1:0] STAT_HIT      = 2'd0;
   localparam logic [1:0] STAT_MISS     = 2'd1;
   localparam logic [1:0] STAT_UPDATED  = 2'd2;
   localparam logic [1:0] STAT_REPLACED = 2'd3;

   typedef struct packed {
      logic        func;
      logic [31:0] ip_addr;
      logic [47:0] mac_in;
      logic [63:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [47:0]       mac_out;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [63:0] stamp;
   } entry_type;

   // Sequencer to scan unit
   typedef struct packed {
      logic             start;
      logic             issue;
      logic [IDX_W-1:0] rd_idx;
      logic [31:0]      key_ip;
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      entry_type        wr_entry;
   } scan_ctl_type;

   // Scan unit to sequencer
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] match_idx;
      logic [47:0]      hit_mac;
      logic [IDX_W-1:0] victim_idx;
   } scan_res_type;

endpackage

>>> hw/rtl/arp_cache_lru_table.sv
// ARP cache table: IPv4 to MAC lookup with oldest-entry replacement.
//
// Requests arrive on req_item with req_valid; a request is transferred at a
// rising edge where req_valid is high and req_stall is low. func 0 looks up
// ip_addr, func 1 stores ip_addr -> mac_in. now_time stamps the entry.
// Each request yields exactly one response on rsp_item, held with rsp_valid
// until a transfer (rsp_valid high and rsp_stall low).
// A lookup of 255.255.255.255 skips the walk and answers the broadcast MAC.
// Any other request walks the table one entry per cycle through the single
// read port of the entry store: S_SCAN reads every entry, S_FLUSH finishes
// the last compare and S_DONE writes back and loads the response. One
// request is in flight at a time; req_stall is high from the transfer until
// the response has been loaded.
// If the receiver stalls, the finished response waits in the sequencer and
// the table write-back waits with it.
// Reset clears all valid bits, so the table starts empty; no clearing pass.
module arp_cache_lru_table import arpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   req_type          item_ff, item_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   scan_ctl_type ctl;
   scan_res_type res;

   logic             accept;
   logic             out_free;
   logic             req_bcast;
   logic             item_bcast;
   logic [IDX_W-1:0] put_idx;
   logic [IDX_W+SLOT_W-1:0] slot_wide;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_bcast  = (req_item.func == FUNC_QUERY) && (req_item.ip_addr == BCAST_IP);
   assign item_bcast = (item_ff.func == FUNC_QUERY) && (item_ff.ip_addr == BCAST_IP);
   assign put_idx    = res.found ? res.match_idx : res.victim_idx;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      ctl          = '0;
      ctl.rd_idx   = cnt_ff;
      ctl.key_ip   = item_ff.ip_addr;
      slot_wide    = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in   = req_item;
               cnt_in    = '0;
               ctl.start = !req_bcast;
               state_in  = req_bcast ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.issue = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               ctl.wr_entry.ip    = item_ff.ip_addr;
               ctl.wr_entry.stamp = item_ff.now_time;
               if (item_ff.func == FUNC_QUERY) begin
                  ctl.wr_entry.mac = res.hit_mac;
                  if (item_bcast) begin
                     rsp_in.status  = STAT_HIT;
                     rsp_in.mac_out = BCAST_MAC;
                     rsp_in.slot    = '0;
                  end else if (res.found) begin
                     // refresh the stamp of the hit entry
                     ctl.wr_en      = 1'b1;
                     ctl.wr_idx     = res.match_idx;
                     slot_wide      = {{SLOT_W{1'b0}}, res.match_idx};
                     rsp_in.status  = STAT_HIT;
                     rsp_in.mac_out = res.hit_mac;
                     rsp_in.slot    = slot_wide[SLOT_W-1:0];
                  end else begin
                     rsp_in.status  = STAT_MISS;
                     rsp_in.mac_out = '0;
                     rsp_in.slot    = '0;
                  end
               end else begin
                  ctl.wr_en        = 1'b1;
                  ctl.wr_idx       = put_idx;
                  ctl.wr_entry.mac = item_ff.mac_in;
                  slot_wide        = {{SLOT_W{1'b0}}, put_idx};
                  rsp_in.status    = res.found ? STAT_UPDATED : STAT_REPLACED;
                  rsp_in.mac_out   = '0;
                  rsp_in.slot      = slot_wide[SLOT_W-1:0];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   arpc_scan_unit u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .res   (res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(rsp_valid_ff) && rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response loaded outside the write-back step");

   a_scan_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_bcast) |=> (state_ff == S_SCAN && cnt_ff == '0))
      else $error("table walk did not start at entry zero");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && cnt_ff == LAST_IDX) |=> (state_ff == S_FLUSH))
      else $error("table walk did not end after the last entry");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !out_free) |=> (state_ff == S_DONE && $stable(item_ff)))
      else $error("write-back left while the response slot was full");
`endif

endmodule

>>> hw/rtl/arpc_scan_unit.sv
// Entry store, valid bits and the shared compare unit that walks the table.
module arpc_scan_unit import arpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  scan_ctl_type ctl,
   output scan_res_type res
);

   entry_type mem [ENTRIES];
   entry_type rd_q_ff;

   logic [ENTRIES-1:0] valid_ff;
   logic               cmp_vld_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;

   logic             found_ff, found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic [47:0]      hit_mac_ff, hit_mac_in;
   logic [IDX_W-1:0] victim_idx_ff, victim_idx_in;
   logic [63:0]      best_stamp_ff, best_stamp_in;

   logic        cur_valid;
   logic [63:0] cur_stamp;
   logic        ip_eq;
   logic        older;

   // Entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_idx] <= ctl.wr_entry;
      end
      rd_q_ff <= mem[ctl.rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[ctl.wr_idx] <= 1'b1;
         end
         cmp_vld_ff <= ctl.issue;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff    <= ctl.rd_idx;
      found_ff      <= found_in;
      match_idx_ff  <= match_idx_in;
      hit_mac_ff    <= hit_mac_in;
      victim_idx_ff <= victim_idx_in;
      best_stamp_ff <= best_stamp_in;
   end

   // One address compare and one stamp compare per cycle
   always_comb begin
      cur_valid = valid_ff[cmp_idx_ff];
      cur_stamp = cur_valid ? rd_q_ff.stamp : 64'd0;
      ip_eq     = cur_valid && (rd_q_ff.ip == ctl.key_ip);
      older     = (cmp_idx_ff == '0) || (cur_stamp < best_stamp_ff);

      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      hit_mac_in    = hit_mac_ff;
      victim_idx_in = victim_idx_ff;
      best_stamp_in = best_stamp_ff;

      if (ctl.start) begin
         found_in = 1'b0;
      end else if (cmp_vld_ff) begin
         // keep the lowest matching index
         if (ip_eq && !found_ff) begin
            found_in     = 1'b1;
            match_idx_in = cmp_idx_ff;
            hit_mac_in   = rd_q_ff.mac;
         end
         if (older) begin
            victim_idx_in = cmp_idx_ff;
            best_stamp_in = cur_stamp;
         end
      end
   end

   assign res.found      = found_ff;
   assign res.match_idx  = match_idx_ff;
   assign res.hit_mac    = hit_mac_ff;
   assign res.victim_idx = victim_idx_ff;

`ifndef SYNTHESIS
   a_valid_never_drops: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((valid_ff & $past(valid_ff)) == $past(valid_ff)))
      else $error("valid bit cleared outside reset");

   a_match_is_valid: assert property (@(posedge clock) disable iff (reset)
      (cmp_vld_ff && !ctl.start && ip_eq && !found_ff) |=> (found_ff && valid_ff[match_idx_ff]))
      else $error("match recorded on an invalid entry");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |=> (valid_ff != '0))
      else $error("write left every entry invalid");
`endif

endmodule
